// ===== rtl/utf8_validate_quote_escape_macros.svh =====
// Assertion macros shared by the UTF-8 validator and quote escaper.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef UTF8_VALIDATE_QUOTE_ESCAPE_MACROS_SVH
`define UTF8_VALIDATE_QUOTE_ESCAPE_MACROS_SVH

// Check that a condition holds at every sampled edge
`define UVQE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the same cycle
`define UVQE_ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// Check that a trigger in one cycle implies a condition in the next cycle
`define UVQE_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/uvqe_pkg.sv =====
// Package for the UTF-8 validator with quote escaping.
// Holds byte constants, the lead byte decoder and the result struct; no dependencies.
package uvqe_pkg;

    localparam logic [7:0] QUOTE_BYTE = 8'h27;
    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] CONT_MAX   = 8'hBF;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD5_MIN  = 8'hF8;
    localparam logic [7:0] LEAD6_MIN  = 8'hFC;
    localparam logic [7:0] LEAD_LIMIT = 8'hFE;
    localparam logic [7:0] SEC3_MIN   = 8'hA0;
    localparam logic [7:0] SEC4_MIN   = 8'h90;
    localparam logic [7:0] SEC5_MIN   = 8'h88;
    localparam logic [7:0] SEC6_MIN   = 8'h84;

    // Outcome of decoding a byte seen with no continuation owed
    typedef struct packed {
        logic       ok;
        logic [2:0] owed;
        logic       check;
        logic [7:0] minimum;
    } lead_t;

    // One result item handed from the checker to the output stage
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       ok;
        logic       dup;
    } result_t;

    function automatic lead_t lead_decode(input logic [7:0] c);
        lead_t d;
        d.ok      = 1'b1;
        d.owed    = 3'd0;
        d.check   = 1'b0;
        d.minimum = CONT_MIN;
        if (c < CONT_MIN) begin
            d.ok = 1'b1;
        end else if (c < LEAD2_MIN) begin
            d.ok = 1'b0;
        end else if (c < LEAD3_MIN) begin
            d.owed = 3'd1;
        end else if (c < LEAD4_MIN) begin
            d.owed    = 3'd2;
            d.check   = (c == LEAD3_MIN);
            d.minimum = (c == LEAD3_MIN) ? SEC3_MIN : CONT_MIN;
        end else if (c < LEAD5_MIN) begin
            d.owed    = 3'd3;
            d.check   = (c == LEAD4_MIN);
            d.minimum = (c == LEAD4_MIN) ? SEC4_MIN : CONT_MIN;
        end else if (c < LEAD6_MIN) begin
            d.owed    = 3'd4;
            d.check   = (c == LEAD5_MIN);
            d.minimum = (c == LEAD5_MIN) ? SEC5_MIN : CONT_MIN;
        end else if (c < LEAD_LIMIT) begin
            d.owed    = 3'd5;
            d.check   = (c == LEAD6_MIN);
            d.minimum = (c == LEAD6_MIN) ? SEC6_MIN : CONT_MIN;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== rtl/uvqe_check.sv =====
// UTF-8 sequence checker: holds the per-string state and forms the result of one byte.
// Depends on uvqe_pkg.
module uvqe_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        byte_in,
    input  logic              last_in,
    input  logic              advance,
    output uvqe_pkg::result_t res
);
    import uvqe_pkg::*;

    logic [2:0] owed_reg, owed_next;
    logic       check_reg, check_next;
    logic [7:0] min_reg, min_next;
    logic       err_reg, err_next;

    lead_t      lead;
    logic       cont_ok;
    logic       byte_ok;
    logic       err_any;

    // Judge the byte against the current sequence state
    always_comb begin
        lead    = lead_decode(byte_in);
        cont_ok = (byte_in >= CONT_MIN) && (byte_in <= CONT_MAX)
                  && !(check_reg && (byte_in < min_reg));
        byte_ok = (owed_reg != 3'd0) ? cont_ok : lead.ok;
        err_any = err_reg || !byte_ok;

        owed_next  = owed_reg;
        check_next = check_reg;
        min_next   = min_reg;
        err_next   = err_reg;
        if (err_any) begin
            err_next = 1'b1;
        end else if (owed_reg != 3'd0) begin
            owed_next  = owed_reg - 3'd1;
            check_next = 1'b0;
            min_next   = CONT_MIN;
        end else if (lead.owed != 3'd0) begin
            owed_next  = lead.owed;
            check_next = lead.check;
            min_next   = lead.minimum;
        end
    end

    // Form the result: echo a good byte, or report status only on the last byte
    always_comb begin
        if (err_any) begin
            res.emit    = last_in;
            res.data    = 8'h00;
            res.present = 1'b0;
            res.last    = 1'b1;
            res.ok      = 1'b0;
            res.dup     = 1'b0;
        end else begin
            res.emit    = 1'b1;
            res.data    = byte_in;
            res.present = 1'b1;
            res.last    = last_in;
            res.ok      = last_in && (owed_next == 3'd0);
            res.dup     = (byte_in == QUOTE_BYTE);
        end
    end

    // Advance the state; clear it at the end of each string
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg  <= 3'd0;
            check_reg <= 1'b0;
            min_reg   <= CONT_MIN;
            err_reg   <= 1'b0;
        end else if (advance) begin
            if (last_in) begin
                owed_reg  <= 3'd0;
                check_reg <= 1'b0;
                min_reg   <= CONT_MIN;
                err_reg   <= 1'b0;
            end else begin
                owed_reg  <= owed_next;
                check_reg <= check_next;
                min_reg   <= min_next;
                err_reg   <= err_next;
            end
        end
    end

`include "utf8_validate_quote_escape_macros.svh"

    `UVQE_ASSERT_ALWAYS(a_owed_range, owed_reg <= 3'd5, "continuation count out of range")
    `UVQE_ASSERT_IMPL(a_check_owed, check_reg, owed_reg != 3'd0, "second-byte check with nothing owed")
    `UVQE_ASSERT_NEXT(a_last_clears, advance && last_in, owed_reg == 3'd0 && !err_reg, "state not cleared after last byte")

endmodule

// ===== rtl/uvqe_emit.sv =====
// Output register stage: presents results and sends a quote a second time.
// Depends on uvqe_pkg.
module uvqe_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  uvqe_pkg::result_t res,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import uvqe_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       present_reg;
    logic       last_reg;
    logic       ok_reg;
    logic       dup_reg;
    logic       dup_last_reg;
    logic       dup_ok_reg;
    logic       xfer;

    assign xfer     = valid_reg && m_tready;
    assign can_load = !valid_reg || (m_tready && !dup_reg);

    // Load a new result, repeat a quote, or drop the register once transferred
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dup_reg   <= 1'b0;
        end else if (xfer && dup_reg) begin
            dup_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            dup_reg   <= res.dup;
        end else if (xfer) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload: the first copy of a quote is never final
    always_ff @(posedge aclk) begin
        if (xfer && dup_reg) begin
            last_reg <= dup_last_reg;
            ok_reg   <= dup_ok_reg;
        end else if (load) begin
            data_reg     <= res.data;
            present_reg  <= res.present;
            last_reg     <= res.last && !res.dup;
            ok_reg       <= res.ok && !res.dup;
            dup_last_reg <= res.last;
            dup_ok_reg   <= res.ok;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = {ok_reg, present_reg};
    assign m_tlast  = last_reg;

`include "utf8_validate_quote_escape_macros.svh"

    `UVQE_ASSERT_IMPL(a_dup_valid, dup_reg, valid_reg && data_reg == QUOTE_BYTE && present_reg, "repeat pending without a quote")
    `UVQE_ASSERT_IMPL(a_dup_not_last, dup_reg, !last_reg && !ok_reg, "first quote copy marked final")
    `UVQE_ASSERT_NEXT(a_dup_follows, xfer && dup_reg, valid_reg && !dup_reg, "second quote copy missing")
    `UVQE_ASSERT_IMPL(a_status_last, valid_reg && !present_reg, last_reg && !ok_reg, "status result not final or marked good")

endmodule

// ===== rtl/utf8_validate_quote_escape.sv =====
// UTF-8 validator with single-quote doubling, streaming top level.
// Depends on uvqe_pkg, uvqe_check and uvqe_emit.
//
// Usage:
//   The input channel carries one string byte per transfer on s_tdata, with
//   s_tlast on the final byte of the string. The result channel carries the
//   echoed bytes on m_tdata; m_tuser[0] says a byte is present and m_tuser[1]
//   gives the string's validity on the final result, which has m_tlast set.
//   A quote byte is sent twice. After the first error in a string nothing is
//   sent until its last byte, which yields one status-only result.
// Timing:
//   An input transfer passes the input register and then the output register
//   before its first result is on m_*. Throughput is one byte per cycle while
//   m_tready is high; a quote holds the input until its second copy is sent.
//   Bytes that yield no result pass the checker without waiting on the output.
// Reset and stalls:
//   aresetn low clears both stages and the sequence state. When m_tready is
//   low the output register holds, the input register fills and s_tready
//   drops until the stalled result is transferred.
module utf8_validate_quote_escape (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] byte_present, [1] string_ok
    output logic       m_tlast
);
    import uvqe_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_move;
    logic       can_load;
    result_t    res;

    assign in_move  = in_valid_reg && (can_load || !res.emit);
    assign s_tready = !in_valid_reg || in_move;

    // Hold the accepted byte until the checker passes it on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    uvqe_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .advance (in_move),
        .res     (res)
    );

    uvqe_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_move && res.emit),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/utf8_validate_quote_escape_test.sv =====
// Self-checking testbench for the UTF-8 validator with quote doubling.
// Predicts every result from the accepted bytes and compares on the result channel.
// Depends on uvqe_pkg and utf8_validate_quote_escape.
`timescale 1ns / 100ps

module utf8_validate_quote_escape_test;
    import uvqe_pkg::*;

    localparam int RANDOM_ITEMS   = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_PRINTED    = 100;

    // One pending input byte, with flow control marks for the sender
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pause;
        logic       hold;
    } pending_byte_t;

    // One escaped result as it should leave the block
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       ok;
    } escaped_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    pending_byte_t pending_q[$];
    escaped_t      escaped_q[$];

    // Sequence state of the predictor
    logic [2:0] seq_owed  = 3'd0;
    logic       seq_check = 1'b0;
    logic [7:0] seq_floor = CONT_MIN;
    logic       seq_bad   = 1'b0;

    int  mismatches  = 0;
    int  result_num  = 0;
    int  idle_cycles = 0;
    bit  in_taken    = 1'b0;
    int  tx_gap      = 0;
    int  tx_burst    = 0;
    int  rx_stall    = 0;
    int  rx_burst    = 0;
    int  hold_left   = 0;
    int  hold_asked  = 0;
    int  hold_seen   = 0;

    utf8_validate_quote_escape dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Pick an idle length: mostly none, some short, a few long, with idle-free bursts
    function automatic int idle_len(inout int burst);
        int r;
        if (burst > 0) begin
            burst = burst - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic void clear_seq();
        seq_owed  = 3'd0;
        seq_check = 1'b0;
        seq_floor = CONT_MIN;
        seq_bad   = 1'b0;
    endfunction

    function automatic void open_seq(input logic [2:0] owed, input logic first,
                                     input logic [7:0] floor_val);
        seq_owed  = owed;
        seq_check = first;
        seq_floor = first ? floor_val : CONT_MIN;
    endfunction

    // Advance the sequence state by one byte; return 0 if the byte breaks UTF-8
    function automatic bit utf8_accept(input logic [7:0] c);
        if (seq_owed != 3'd0) begin
            if (c < CONT_MIN || c > CONT_MAX)
                return 1'b0;
            if (seq_check && c < seq_floor)
                return 1'b0;
            seq_check = 1'b0;
            seq_floor = CONT_MIN;
            seq_owed  = seq_owed - 3'd1;
            return 1'b1;
        end
        if (c < CONT_MIN)
            return 1'b1;
        if (c < LEAD2_MIN)
            return 1'b0;
        if (c < LEAD3_MIN)
            open_seq(3'd1, 1'b0, CONT_MIN);
        else if (c < LEAD4_MIN)
            open_seq(3'd2, c == LEAD3_MIN, SEC3_MIN);
        else if (c < LEAD5_MIN)
            open_seq(3'd3, c == LEAD4_MIN, SEC4_MIN);
        else if (c < LEAD6_MIN)
            open_seq(3'd4, c == LEAD5_MIN, SEC5_MIN);
        else if (c < LEAD_LIMIT)
            open_seq(3'd5, c == LEAD6_MIN, SEC6_MIN);
        else
            return 1'b0;
        return 1'b1;
    endfunction

    // Append one expected result to the scoreboard
    function automatic void append_result(input logic [7:0] data, input logic present,
                                          input logic last, input logic ok);
        escaped_t x;
        x = '{data, present, last, ok};
        escaped_q.insert(escaped_q.size(), x);
    endfunction

    // Queue the escaped results that one accepted byte causes
    function automatic void predict_escape(input logic [7:0] c, input logic last);
        logic whole;
        if (!seq_bad && !utf8_accept(c))
            seq_bad = 1'b1;
        if (seq_bad) begin
            if (last) begin
                append_result(8'h00, 1'b0, 1'b1, 1'b0);
                clear_seq();
            end
            return;
        end
        whole = (seq_owed == 3'd0);
        if (c == QUOTE_BYTE)
            append_result(c, 1'b1, 1'b0, 1'b0);
        append_result(c, 1'b1, last, last && whole);
        if (last)
            clear_seq();
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH result %0d %s: expected %0h, got %0h", result_num, field,
                     want, got);
        mismatches++;
    endtask

    // Queue one byte; pause and hold marks fall on fixed positions in the stream
    task automatic add_byte(input logic [7:0] b, input logic last);
        int idx;
        pending_byte_t p;
        idx = pending_q.size();
        p = '{b, last, (idx == 28 || idx == 400), (idx == 150 || idx == 550)};
        pending_q.insert(pending_q.size(), p);
    endtask

    // Queue a whole string given high byte first, last flag on its final byte
    task automatic add_packed(input logic [63:0] bytes, input int n);
        for (int i = 0; i < n; i++)
            add_byte(bytes[8 * (n - 1 - i) +: 8], i == n - 1);
    endtask

    // Sample both handshakes, predict on input transfers, check on result transfers
    always @(posedge aclk) begin : monitor
        escaped_t e;
        if (!aresetn) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready)
                predict_escape(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (escaped_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 8'h00, m_tdata);
                end else begin
                    e = escaped_q.pop_front();
                    if (m_tuser[0] !== e.present)
                        report_mismatch("byte_present", 8'(e.present), 8'(m_tuser[0]));
                    if (m_tdata !== e.data)
                        report_mismatch("out_byte", e.data, m_tdata);
                    if (m_tlast !== e.last)
                        report_mismatch("out_last", 8'(e.last), 8'(m_tlast));
                    if (m_tuser[1] !== e.ok)
                        report_mismatch("string_ok", 8'(e.ok), 8'(m_tuser[1]));
                end
                result_num++;
            end
        end
    end

    // Offer the next pending byte once the current one is taken and any gap has run out
    always @(negedge aclk) begin : driver
        pending_byte_t item;
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (tx_gap > 0) begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].pause && escaped_q.size() != 0)) begin
                item = pending_q.pop_front();
                if (item.hold)
                    hold_asked <= hold_asked + 1;
                s_tvalid <= 1'b1;
                s_tdata  <= item.data;
                s_tlast  <= item.last;
                tx_gap   <= idle_len(tx_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random, with a long hold when the sender asks
    always @(negedge aclk) begin : receiver
        int n;
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_seen + 1;
        end else if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            n = idle_len(rx_burst);
            m_tready <= (n == 0);
            if (n > 0)
                rx_stall <= n - 1;
        end
    end

    initial begin : stimulus
        logic [7:0] sbytes[$];
        logic [7:0] lo, hi, floor_val, b;
        int         n_chars, form, r, total, pos;

        // Directed strings: lone quote, ASCII and 2-byte extremes, minimal
        // second bytes of 3 and 5 byte forms, overlong of 3, 4 and 6 byte forms,
        // bad leads, final-byte error, quote after an error, cut-short sequence
        add_packed(64'h27, 1);
        add_packed(64'h00_7F_DF_BF, 4);
        add_packed(64'hE0_A0_80, 3);
        add_packed(64'hE0_9F_27, 3);
        add_packed(64'hF0_8F, 2);
        add_packed(64'hF8_88_80_80_80, 5);
        add_packed(64'hFC_83, 2);
        add_packed(64'h80, 1);
        add_packed(64'hFE, 1);
        add_packed(64'hFF, 1);
        add_packed(64'hC1, 1);
        add_packed(64'hC2_41, 2);
        add_packed(64'hE1_80, 2);
        total = pending_q.size() + RANDOM_ITEMS;

        // Random strings: mostly well-formed characters, some noise and damage
        while (pending_q.size() < total) begin
            sbytes.delete();
            n_chars = $urandom_range(1, 10);
            for (int k = 0; k < n_chars; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    sbytes.insert(sbytes.size(), 8'($urandom_range(0, 255)));
                end else if (r < 40) begin
                    if ($urandom_range(0, 4) == 0)
                        sbytes.insert(sbytes.size(), QUOTE_BYTE);
                    else
                        sbytes.insert(sbytes.size(), 8'($urandom_range(0, 127)));
                end else begin
                    form = $urandom_range(2, 6);
                    case (form)
                        2: begin lo = LEAD2_MIN; hi = LEAD3_MIN - 8'd1; floor_val = CONT_MIN; end
                        3: begin lo = LEAD3_MIN; hi = LEAD4_MIN - 8'd1; floor_val = SEC3_MIN; end
                        4: begin lo = LEAD4_MIN; hi = LEAD5_MIN - 8'd1; floor_val = SEC4_MIN; end
                        5: begin lo = LEAD5_MIN; hi = LEAD6_MIN - 8'd1; floor_val = SEC5_MIN; end
                        default: begin
                            lo = LEAD6_MIN; hi = LEAD_LIMIT - 8'd1; floor_val = SEC6_MIN;
                        end
                    endcase
                    b = ($urandom_range(0, 3) == 0) ? lo : 8'($urandom_range(lo, hi));
                    sbytes.insert(sbytes.size(), b);
                    for (int j = 1; j < form; j++) begin
                        if (j == 1 && b == lo)
                            sbytes.insert(sbytes.size(),
                                          8'($urandom_range(floor_val, CONT_MAX)));
                        else
                            sbytes.insert(sbytes.size(),
                                          8'($urandom_range(CONT_MIN, CONT_MAX)));
                    end
                end
            end
            // Damage a few strings: stray byte, cut-short end, or overlong tail
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 2))
                    0: begin
                        pos = $urandom_range(0, sbytes.size() - 1);
                        sbytes[pos] = 8'($urandom_range(0, 255));
                    end
                    1: begin
                        if (sbytes.size() > 1)
                            void'(sbytes.pop_back());
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: begin lo = LEAD3_MIN; floor_val = SEC3_MIN; end
                            1: begin lo = LEAD4_MIN; floor_val = SEC4_MIN; end
                            2: begin lo = LEAD5_MIN; floor_val = SEC5_MIN; end
                            default: begin lo = LEAD6_MIN; floor_val = SEC6_MIN; end
                        endcase
                        sbytes.insert(sbytes.size(), lo);
                        sbytes.insert(sbytes.size(),
                                      8'($urandom_range(CONT_MIN, floor_val - 8'd1)));
                    end
                endcase
            end
            foreach (sbytes[i])
                add_byte(sbytes[i], i == sbytes.size() - 1);
        end

        // Hold reset, then release at a falling edge
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every byte to be taken and every result to arrive
        while (!((pending_q.size() == 0 && !s_tvalid && escaped_q.size() == 0) ||
                 idle_cycles >= WATCHDOG_LIMIT))
            @(posedge aclk);

        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge aclk);
            if (mismatches == 0 && escaped_q.size() == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/uvqe_pkg.sv
rtl/uvqe_check.sv
rtl/uvqe_emit.sv
rtl/utf8_validate_quote_escape.sv
tb/utf8_validate_quote_escape_test.sv
